[rtl/lcr_pkg.sv]
package lcr_pkg;

   localparam int SAMPLE_W = 16;
   localparam int RATE_W   = 19;
   localparam int TAPS     = 4;
   localparam int MAX_OUT  = 64;
   localparam int CNT_W    = 7;

   localparam logic [RATE_W-1:0] RATE_RESET = 19'd65536;

   // interpolation position u is Q0.16; these are 1.0 and 2.0 on that scale
   localparam logic [16:0] U_ONE = 17'd65536;
   localparam logic [17:0] U_TWO = 18'd131072;

   // reciprocal of 3: K = (2^31 + 1) / 3, split into 15-bit halves
   localparam logic signed [18:0] RECIP_LO = 19'sd10923;
   localparam logic signed [18:0] RECIP_HI = 19'sd21845;

   // rounding offsets for the weight scaling
   localparam logic [50:0] BIAS_DIV6 = 51'd786432;   // 3 * 2^18
   localparam logic [50:0] BIAS_DIV2 = 51'd262144;   // 2^18
   localparam logic [48:0] BIAS_OUT  = 49'd536870912; // 2^29

   localparam logic signed [18:0] SAT_MAX = 19'sd32767;
   localparam logic signed [18:0] SAT_MIN = -19'sd32768;

   typedef enum logic [18:0] {
      ST_IDLE  = 19'h00001,
      ST_CHECK = 19'h00002,
      ST_UB    = 19'h00004,
      ST_Q0    = 19'h00008,
      ST_Q3    = 19'h00010,
      ST_AB    = 19'h00020,
      ST_Q1    = 19'h00040,
      ST_AU    = 19'h00080,
      ST_Q2    = 19'h00100,
      ST_D0L   = 19'h00200,
      ST_D0H   = 19'h00400,
      ST_D3L   = 19'h00800,
      ST_D3H   = 19'h01000,
      ST_S0    = 19'h02000,
      ST_S1    = 19'h04000,
      ST_S2    = 19'h08000,
      ST_S3    = 19'h10000,
      ST_S4    = 19'h20000,
      ST_EMIT  = 19'h40000
   } state_type;

endpackage

[rtl/lagrange_cubic_resampler.sv]
// Four-point cubic Lagrange resampler.
// req_*: one 16-bit source sample per word, shifted into a four-sample
//   window (zeros after reset). rsp_*: interpolated samples between the two
//   middle window taps; rsp_tlast marks the final word caused by one input.
// csr_*: write of rate_step (unsigned Q3.16 playback rate, reset 1.0).
//   Write only while the block is idle.
// One input yields zero to 64 output words, depending on the phase and rate.
// req_tready stays low from an accepted input until the run of N words that
//   it yields is done. Each word is built on the single shared 36x19
//   multiplier, which computes the four weights, the divide-by-3 via
//   reciprocal and the four-tap dot product in sequence.
// The result sits in an output register; if rsp_tready is low the next word
//   is computed anyway and the sequencer waits only when it must load a new
//   word into a still-full register. A new input can be accepted while the
//   last word of the previous run still waits.
// Reset (synchronous): window and phase cleared, rate back to 1.0, no
//   pending output.
module lagrange_cubic_resampler #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] sample_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] sample_out
   output logic        rsp_tlast,   // last_of_run
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [lcr_pkg::RATE_W-1:0] csr_wdata
);
   import lcr_pkg::*;

   localparam int PHASE_W = FRAC_BITS + 4;
   localparam logic [PHASE_W-1:0] PHASE_ONE = {{(PHASE_W-1){1'b0}}, 1'b1} << FRAC_BITS;

   // control state
   state_type                state_ff, state_in;
   logic [RATE_W-1:0]        rate_ff, rate_in;
   logic [PHASE_W-1:0]       phase_ff, phase_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic signed [SAMPLE_W-1:0] win_ff [TAPS];
   logic                     rsp_valid_ff, rsp_valid_in;

   // datapath
   logic [15:0]              u_ff;
   logic [16:0]              a_ff;    // u + 1
   logic [16:0]              bm_ff;   // 1 - u
   logic [17:0]              cm_ff;   // 2 - u
   logic [33:0]              t_ff;
   logic [29:0]              m0_ff, m3_ff;
   logic [29:0]              lo_ff;
   logic [30:0]              w0_ff, w1_ff, w2_ff, w3_ff;   // weight magnitudes, Q30
   logic signed [47:0]       acc_ff;
   logic signed [54:0]       prod_ff;
   logic [15:0]              rsp_data_ff;
   logic                     rsp_last_ff;

   logic signed [35:0]       mul_a;
   logic signed [18:0]       mul_b;
   logic signed [54:0]       prod_in;

   logic [FRAC_BITS+15:0]    frac_wide;
   logic [15:0]              u_now;
   logic [FRAC_BITS+18:0]    step_wide;
   logic [PHASE_W-2:0]       step;
   logic [PHASE_W-1:0]       phase_sum;
   logic                     last_in;
   logic                     emit_go;
   logic                     req_go;
   logic [50:0]              q_div6, q_div2;
   logic [45:0]              recip_sum;
   logic signed [48:0]       round_sum;
   logic signed [18:0]       out_full;
   logic [15:0]              out_sat;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign req_go  = req_tvalid && req_tready;
   assign emit_go = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready);

   // fraction to Q0.16, rate to FRAC_BITS scale
   assign frac_wide = {phase_ff[FRAC_BITS-1:0], 16'b0};
   assign u_now     = frac_wide[FRAC_BITS+15:FRAC_BITS];
   assign step_wide = {rate_ff, {FRAC_BITS{1'b0}}};
   assign step      = step_wide[FRAC_BITS+18:16];
   assign phase_sum = phase_ff + {1'b0, step};
   assign last_in   = (phase_sum >= PHASE_ONE) || (cnt_ff == CNT_W'(MAX_OUT - 1));

   // weight scaling: round(q / (6*2^18)) needs floor((q + 3*2^18) >> 19) / 3,
   // round(q / 2^19) is (q + 2^18) >> 19
   assign q_div6    = prod_ff[50:0] + BIAS_DIV6;
   assign q_div2    = prod_ff[50:0] + BIAS_DIV2;
   assign recip_sum = prod_ff[45:0] + {16'b0, lo_ff};

   // final rounding (ties up) and saturation
   assign round_sum = {acc_ff[47], acc_ff} + $signed(BIAS_OUT);
   assign out_full  = round_sum[48:30];
   always_comb begin
      if (out_full > SAT_MAX) begin
         out_sat = SAT_MAX[15:0];
      end else if (out_full < SAT_MIN) begin
         out_sat = SAT_MIN[15:0];
      end else begin
         out_sat = out_full[15:0];
      end
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff) inside
         ST_UB: begin
            mul_a = {20'b0, u_ff};
            mul_b = {2'b0, bm_ff};
         end
         ST_Q0, ST_Q1, ST_Q2: begin
            mul_a = {2'b0, prod_ff[33:0]};
            mul_b = {1'b0, cm_ff};
         end
         ST_Q3: begin
            mul_a = {2'b0, t_ff};
            mul_b = {2'b0, a_ff};
         end
         ST_AB: begin
            mul_a = {19'b0, a_ff};
            mul_b = {2'b0, bm_ff};
         end
         ST_AU: begin
            mul_a = {19'b0, a_ff};
            mul_b = {3'b0, u_ff};
         end
         ST_D0L: begin
            mul_a = {6'b0, m0_ff};
            mul_b = RECIP_LO;
         end
         ST_D0H: begin
            mul_a = {6'b0, m0_ff};
            mul_b = RECIP_HI;
         end
         ST_D3L: begin
            mul_a = {6'b0, m3_ff};
            mul_b = RECIP_LO;
         end
         ST_D3H: begin
            mul_a = {6'b0, m3_ff};
            mul_b = RECIP_HI;
         end
         ST_S0: begin
            mul_a = 36'sd0 - $signed({5'b0, w0_ff});
            mul_b = {{3{win_ff[0][15]}}, win_ff[0]};
         end
         ST_S1: begin
            mul_a = $signed({5'b0, w1_ff});
            mul_b = {{3{win_ff[1][15]}}, win_ff[1]};
         end
         ST_S2: begin
            mul_a = $signed({5'b0, w2_ff});
            mul_b = {{3{win_ff[2][15]}}, win_ff[2]};
         end
         ST_S3: begin
            mul_a = 36'sd0 - $signed({5'b0, w3_ff});
            mul_b = {{3{win_ff[3][15]}}, win_ff[3]};
         end
         ST_IDLE, ST_CHECK, ST_S4, ST_EMIT: begin
            mul_a = '0;
            mul_b = '0;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      rate_in      = rate_ff;
      phase_in     = phase_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;

      if (csr_valid && csr_ready) begin
         rate_in = csr_wdata;
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_go) begin
               cnt_in   = '0;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if ((phase_ff < PHASE_ONE) && (cnt_ff != CNT_W'(MAX_OUT))) begin
               state_in = ST_UB;
            end else begin
               // end of run: step into the next interval, or give up at the cap
               phase_in = (phase_ff >= PHASE_ONE) ? phase_ff - PHASE_ONE : '0;
               state_in = ST_IDLE;
            end
         end
         ST_UB:  state_in = ST_Q0;
         ST_Q0:  state_in = ST_Q3;
         ST_Q3:  state_in = ST_AB;
         ST_AB:  state_in = ST_Q1;
         ST_Q1:  state_in = ST_AU;
         ST_AU:  state_in = ST_Q2;
         ST_Q2:  state_in = ST_D0L;
         ST_D0L: state_in = ST_D0H;
         ST_D0H: state_in = ST_D3L;
         ST_D3L: state_in = ST_D3H;
         ST_D3H: state_in = ST_S0;
         ST_S0:  state_in = ST_S1;
         ST_S1:  state_in = ST_S2;
         ST_S2:  state_in = ST_S3;
         ST_S3:  state_in = ST_S4;
         ST_S4:  state_in = ST_EMIT;
         ST_EMIT: begin
            if (emit_go) begin
               rsp_valid_in = 1'b1;
               phase_in     = phase_sum;
               cnt_in       = cnt_ff + CNT_W'(1);
               state_in     = ST_CHECK;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rate_ff      <= RATE_RESET;
         phase_ff     <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < TAPS; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rate_ff      <= rate_in;
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_go) begin
            for (int i = 0; i < TAPS - 1; i++) begin
               win_ff[i] <= win_ff[i+1];
            end
            win_ff[TAPS-1] <= req_tdata;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      unique case (state_ff) inside
         ST_CHECK: begin
            u_ff  <= u_now;
            a_ff  <= {1'b0, u_now} + U_ONE;
            bm_ff <= U_ONE - {1'b0, u_now};
            cm_ff <= U_TWO - {2'b0, u_now};
         end
         ST_Q0:  t_ff  <= prod_ff[33:0];
         ST_Q3:  m0_ff <= q_div6[48:19];
         ST_AB:  m3_ff <= q_div6[48:19];
         ST_AU:  w1_ff <= q_div2[49:19];
         ST_D0L: w2_ff <= q_div2[49:19];
         ST_D0H: lo_ff <= prod_ff[44:15];
         ST_D3L: w0_ff <= {1'b0, recip_sum[45:16]};
         ST_D3H: lo_ff <= prod_ff[44:15];
         ST_S0:  w3_ff <= {1'b0, recip_sum[45:16]};
         ST_S1:  acc_ff <= prod_ff[47:0];
         ST_S2, ST_S3, ST_S4: acc_ff <= acc_ff + prod_ff[47:0];
         ST_EMIT: begin
            if (emit_go) begin
               rsp_data_ff <= out_sat;
               rsp_last_ff <= last_in;
            end
         end
         default: begin
         end
      endcase
   end

   // checks
   a_cnt_cap: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_OUT))
      else $error("output count past cap");

   a_phase_in_interval: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UB) |-> (phase_ff < PHASE_ONE))
      else $error("interpolating with phase outside interval");

   a_more_after_nonlast: assert property (@(posedge clock) disable iff (reset)
      (emit_go && !last_in) |=> (state_ff == ST_CHECK) ##1 (state_ff == ST_UB))
      else $error("word not marked last but run ended");

   a_end_after_last: assert property (@(posedge clock) disable iff (reset)
      (emit_go && last_in) |=> (state_ff == ST_CHECK) ##1 (state_ff == ST_IDLE))
      else $error("word marked last but run continued");

endmodule

[tb/sv/tb_lagrange_cubic_resampler.sv]
module tb_lagrange_cubic_resampler;
   import lcr_pkg::*;

   // Phase scale of the instance; the rate register is Q3.16, so at 16 fractional
   // bits the step equals the register value.
   localparam int FRAC = 16;
   localparam logic [63:0] PHASE_ONE = 64'd1 << FRAC;

   // Weights are built at 6 * 2^48 and brought to Q30 by dividing by 6 * 2^18.
   localparam longint W_DEN = 1572864;

   // Worst case is far below this: 64 words per input, each with a random
   // receiver stall, for at most 322 inputs.
   localparam int CYCLE_LIMIT = 3000000;
   localparam int CSR_HOLDOFF = 40;   // an input with no output still runs through the check state
   localparam int SETTLE      = 100;

   typedef struct packed {
      logic [15:0] sample;
      logic        last;
   } rsp_word_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [15:0]         req_tdata  = '0;     // [15:0] sample_in
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [15:0]         rsp_tdata;           // [15:0] sample_out
   logic                rsp_tlast;           // last_of_run
   logic                csr_valid  = 1'b0;
   logic                csr_ready;
   logic [RATE_W-1:0]   csr_wdata  = '0;     // rate_step

   // Local copy of the resampler state
   logic [RATE_W-1:0]   model_rate;
   logic signed [15:0]  model_win [TAPS];
   logic [63:0]         model_phase;

   logic [15:0]         src_queue [$];       // samples waiting to be sent
   rsp_word_type        resampled_q [$];     // words predicted, not yet seen
   rsp_word_type        rx_expect;

   int                  errors      = 0;
   int                  cycle_count = 0;
   int                  tx_gap;
   int                  rx_wait;
   bit                  tx_calm     = 1'b0;  // no gaps on the sample side
   bit                  rx_calm     = 1'b0;  // no stalls on the output side

   lagrange_cubic_resampler #(
      .FRAC_BITS (FRAC)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   // Lagrange weight rounded to Q30, ties away from zero
   function automatic longint q30_weight(input longint num);
      if (num >= 0)
         return (num + W_DEN / 2) / W_DEN;
      return -((-num + W_DEN / 2) / W_DEN);
   endfunction

   // Cubic through the four taps at node 1 + frac, frac in Q0.16
   function automatic logic [15:0] lagrange_point(input logic [15:0] frac);
      longint u, p0, p1, p2, p3, acc;
      u   = longint'({48'd0, frac});
      p0  = -(u * (u - 65536)) * (u - 131072);
      p1  = 3 * ((u + 65536) * (u - 65536)) * (u - 131072);
      p2  = -3 * ((u + 65536) * u) * (u - 131072);
      p3  = ((u + 65536) * u) * (u - 65536);
      acc = longint'(model_win[0]) * q30_weight(p0)
          + longint'(model_win[1]) * q30_weight(p1)
          + longint'(model_win[2]) * q30_weight(p2)
          + longint'(model_win[3]) * q30_weight(p3);
      // round half up, then saturate to 16 bits
      acc = (acc + 64'sd536870912) >>> 30;
      if (acc < -32768)
         acc = -32768;
      if (acc > 32767)
         acc = 32767;
      return acc[15:0];
   endfunction

   // Shift one sample in and queue every word it causes
   function automatic void predict_input(input logic [15:0] din);
      int           n;
      rsp_word_type w;
      for (int i = 0; i < TAPS - 1; i++)
         model_win[i] = model_win[i + 1];
      model_win[TAPS - 1] = din;
      n = 0;
      while (model_phase < PHASE_ONE && n < MAX_OUT) begin
         w.sample = lagrange_point(model_phase[15:0]);
         model_phase += 64'(model_rate);
         n++;
         // last word: the phase left the interval, or the 64-word cap was hit
         w.last = (model_phase >= PHASE_ONE) || (n == MAX_OUT);
         resampled_q.push_back(w);
      end
      if (model_phase >= PHASE_ONE)
         model_phase -= PHASE_ONE;
      else
         model_phase = '0;   // cap hit with the phase still inside: cleared
   endfunction

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(0, 7))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'($urandom_range(0, 64)) - 16'd32;   // near zero
         default: return 16'($urandom());
      endcase
   endfunction

   // Single rate write; only called with the block idle
   task automatic set_rate(input logic [RATE_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid  <= 1'b0;
      model_rate = value;
   endtask

   // Wait until every sample is taken and every predicted word has arrived.
   // Checked on the falling edge so the queues are settled.
   task automatic drain(input int tail);
      do
         @(negedge clock);
      while (src_queue.size() != 0 || req_tvalid || resampled_q.size() != 0);
      repeat (tail) @(negedge clock);
   endtask

   // Sample driver: one word per pop, random gap after each accepted word
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         tx_gap = 0;
      end else begin
         if (req_tvalid && req_tready)
            predict_input(req_tdata);
         if (req_tvalid && !req_tready) begin
            // word still offered, hold it
         end else if (tx_gap > 0) begin
            tx_gap--;
            req_tvalid <= 1'b0;
         end else if (src_queue.size() > 0) begin
            req_tdata  <= src_queue.pop_front();
            req_tvalid <= 1'b1;
            tx_gap = tx_calm ? 0 : $urandom_range(0, 14);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Output monitor: random stall after each word, compare with oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_wait = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (resampled_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected word: sample %h last %b", rsp_tdata, rsp_tlast);
            end else begin
               rx_expect = resampled_q.pop_front();
               if (rx_expect.sample !== rsp_tdata || rx_expect.last !== rsp_tlast) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: expected sample %h last %b, got sample %h last %b",
                              rx_expect.sample, rx_expect.last, rsp_tdata, rsp_tlast);
               end
            end
            rx_wait = rx_calm ? 0 : $urandom_range(0, 14);
         end
         if (rx_wait > 0) begin
            rx_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** lagrange_cubic_resampler: FAILED **");
         $finish;
      end
   end

   initial begin
      int                items_queued;
      int                n;
      logic [RATE_W-1:0] r;

      model_rate  = RATE_RESET;
      model_phase = '0;
      for (int i = 0; i < TAPS; i++)
         model_win[i] = '0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset rate of 1.0 left as is: one word per sample, sample extremes
      @(negedge clock);
      src_queue.push_back(16'h7FFF);
      src_queue.push_back(16'h8000);
      src_queue.push_back(16'h0000);
      src_queue.push_back(16'hFFFF);
      src_queue.push_back(16'h0001);
      src_queue.push_back(16'hAAAA);
      drain(CSR_HOLDOFF);

      // Half rate over alternating pairs of full-scale taps: overshoot must saturate
      set_rate(19'd32768);
      @(negedge clock);
      src_queue.push_back(16'h8000);
      src_queue.push_back(16'h7FFF);
      src_queue.push_back(16'h7FFF);
      src_queue.push_back(16'h8000);
      src_queue.push_back(16'h8000);
      src_queue.push_back(16'h7FFF);
      drain(CSR_HOLDOFF);

      // Lowest legal rate, 1/64: exactly 64 words per input
      set_rate(19'd1024);
      @(negedge clock);
      src_queue.push_back(16'h4000);
      src_queue.push_back(16'hC000);
      src_queue.push_back(16'h7FFF);
      drain(CSR_HOLDOFF);

      // Rate zero: run stops at the cap, phase cleared
      set_rate(19'd0);
      @(negedge clock);
      src_queue.push_back(16'h1234);
      src_queue.push_back(16'h8001);
      drain(CSR_HOLDOFF);

      // All-ones rate: heavy downsampling, most inputs give nothing
      set_rate('1);
      @(negedge clock);
      for (int i = 0; i < 6; i++)
         src_queue.push_back(pick_sample());
      drain(CSR_HOLDOFF);

      // Random phases, one rate each
      items_queued = 0;
      while (items_queued < 260) begin
         case ($urandom_range(0, 7)) inside
            0:       r = 19'd1024;
            1:       r = 19'd262144;
            2:       r = '1;
            3:       r = 19'($urandom_range(0, 1023));     // below 1/64, cap
            4, 5:    r = 19'($urandom_range(1024, 262144));
            6:       r = 19'($urandom());
            default: r = 19'($urandom_range(32768, 98304));
         endcase
         // slow rates give up to 64 words per input, keep those phases short
         n = (r < 19'd4096) ? 4 : 24 + $urandom_range(0, 16);
         tx_calm = ($urandom_range(0, 3) == 0);
         rx_calm = ($urandom_range(0, 3) == 0);
         set_rate(r);
         @(negedge clock);
         for (int i = 0; i < n / 2; i++)
            src_queue.push_back(pick_sample());
         // sender holds off until every word so far is out
         drain(0);
         for (int i = n / 2; i < n; i++)
            src_queue.push_back(pick_sample());
         drain(CSR_HOLDOFF);
         items_queued += n;
      end

      drain(SETTLE);
      if (errors == 0 && resampled_q.size() == 0)
         $display("** lagrange_cubic_resampler: PASSED **");
      else
         $display("** lagrange_cubic_resampler: FAILED **");
      $finish;
   end

endmodule
